### rtl/sui_pkg.sv
// ---------------------------------------------------------------------------
// sui_pkg: shared types and constants of the set union/intersection engine
// Holds the set capacity, the derived widths, the command, list and status
// codes, the controller state type and the control/status bundles.
// ---------------------------------------------------------------------------
package sui_pkg;

  localparam int SET_CAPACITY = 128;
  localparam int IDX_W = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
  localparam int CNT_W = $clog2(SET_CAPACITY + 1);
  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int LEN_W = 9;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_INS_A = 2'd1,
    CMD_INS_B = 2'd2,
    CMD_READ  = 2'd3
  } sui_cmd_t;

  typedef enum logic [1:0] {
    LIST_UNION     = 2'd0,
    LIST_INTER     = 2'd1,
    LIST_A_MINUS_B = 2'd2,
    LIST_B_MINUS_A = 2'd3
  } sui_list_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_DUP   = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } sui_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WALK,
    S_FINISH
  } sui_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic walk;
    logic finish;
  } sui_ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic seq_done;
  } sui_sts_t;

  // Clamp a set size to the width of the length field
  function automatic logic [LEN_W-1:0] len_sat(input logic [CNT_W-1:0] n);
    logic [CNT_W+LEN_W-1:0] wide;
    wide = {{LEN_W{1'b0}}, n};
    if (wide > (CNT_W + LEN_W)'(LEN_MAX)) begin
      return LEN_MAX;
    end else begin
      return wide[LEN_W-1:0];
    end
  endfunction

endpackage

### rtl/sui_ctrl.sv
// ---------------------------------------------------------------------------
// sui_ctrl: command sequencer of the set union/intersection engine
// Takes one item at a time and steps the datapath through search, walk
// and finish phases.
// ---------------------------------------------------------------------------
module sui_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        command,
  input  sui_pkg::sui_sts_t sts,
  output sui_pkg::sui_ctl_t ctl,
  output logic              busy
);

  sui_pkg::sui_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sui_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      sui_pkg::S_IDLE: begin
        if (start) begin
          unique case (sui_pkg::sui_cmd_t'(command))
            sui_pkg::CMD_CLEAR: state_next = sui_pkg::S_FINISH;
            sui_pkg::CMD_INS_A: state_next = sui_pkg::S_SCAN;
            sui_pkg::CMD_INS_B: state_next = sui_pkg::S_SCAN;
            sui_pkg::CMD_READ:  state_next = sui_pkg::S_WALK;
          endcase
        end
      end
      sui_pkg::S_SCAN: begin
        if (sts.seq_done) state_next = sui_pkg::S_FINISH;
      end
      sui_pkg::S_WALK: begin
        if (sts.seq_done) state_next = sui_pkg::S_FINISH;
      end
      sui_pkg::S_FINISH: state_next = sui_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctl.load   = (state == sui_pkg::S_IDLE) && start;
    ctl.scan   = (state == sui_pkg::S_SCAN);
    ctl.walk   = (state == sui_pkg::S_WALK);
    ctl.finish = (state == sui_pkg::S_FINISH);
    busy       = (state != sui_pkg::S_IDLE);
  end

endmodule

### rtl/sui_datapath.sv
// ---------------------------------------------------------------------------
// sui_datapath: set storage and entry walker
// Holds both sets in memories with shared flags, streams entries one per
// cycle for membership search and positional reads, and forms the result.
// ---------------------------------------------------------------------------
module sui_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  sui_pkg::sui_ctl_t                   ctl,
  output sui_pkg::sui_sts_t                   sts,
  input  logic [1:0]                          command,
  input  logic signed [sui_pkg::VAL_W-1:0]    element_value,
  input  logic [1:0]                          list_select,
  input  logic [sui_pkg::POS_W-1:0]           position,
  output logic                                done,
  output logic [1:0]                          status,
  output logic signed [sui_pkg::VAL_W-1:0]    read_value,
  output logic [sui_pkg::LEN_W-1:0]           list_length
);

  localparam int IDX_W = sui_pkg::IDX_W;
  localparam int CNT_W = sui_pkg::CNT_W;
  localparam int VAL_W = sui_pkg::VAL_W;
  localparam int LEN_W = sui_pkg::LEN_W;

  // Set storage
  logic [VAL_W-1:0] a_val_mem [sui_pkg::SET_CAPACITY];
  logic [VAL_W-1:0] b_val_mem [sui_pkg::SET_CAPACITY];
  logic             a_sh_mem  [sui_pkg::SET_CAPACITY];
  logic             b_sh_mem  [sui_pkg::SET_CAPACITY];

  // Captured item
  sui_pkg::sui_cmd_t  cmd_q;
  sui_pkg::sui_list_t sel_q;
  logic [VAL_W-1:0]   value_q;
  logic [sui_pkg::POS_W-1:0] pos_q;

  logic [CNT_W-1:0] size_a, size_b, idx;
  logic             phase_b;
  logic             pipe_a_v, pipe_b_v;
  logic [IDX_W-1:0] pipe_idx;
  logic [VAL_W-1:0] a_val_rd, b_val_rd;
  logic             a_sh_rd, b_sh_rd;

  logic             found_a, found_b;
  logic [IDX_W-1:0] found_a_idx, found_b_idx;
  logic             hit;
  logic [VAL_W-1:0] hit_val;
  logic [LEN_W-1:0] cnt;

  logic             issue_a, issue_b, wrap, issue_done;
  logic             ent_sh, keep;
  logic [VAL_W-1:0] ent_val;
  logic             own_found, own_full, ins_ok;
  logic [CNT_W-1:0] own_size, new_size;
  logic             a_val_we, b_val_we, a_sh_we, b_sh_we;
  logic [IDX_W-1:0] a_sh_waddr, b_sh_waddr;
  logic             a_sh_wdata, b_sh_wdata;

  // Issue control: search walks both sets at once, reads walk A, B or both
  always_comb begin
    wrap = 1'b0;
    if (ctl.scan) begin
      issue_a    = idx < size_a;
      issue_b    = idx < size_b;
      issue_done = (idx >= size_a) && (idx >= size_b);
    end else if (ctl.walk) begin
      issue_a    = !phase_b && (idx < size_a);
      issue_b    = phase_b && (idx < size_b);
      wrap       = !phase_b && (idx >= size_a) && (sel_q == sui_pkg::LIST_UNION);
      issue_done = phase_b ? (idx >= size_b)
                           : ((idx >= size_a) && (sel_q != sui_pkg::LIST_UNION));
    end else begin
      issue_a    = 1'b0;
      issue_b    = 1'b0;
      issue_done = 1'b1;
    end
    sts.seq_done = issue_done && !pipe_a_v && !pipe_b_v;
  end

  // Advance the walk index and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_a_v <= 1'b0;
      pipe_b_v <= 1'b0;
      idx      <= '0;
      phase_b  <= 1'b0;
    end else begin
      pipe_a_v <= issue_a;
      pipe_b_v <= issue_b;
      if (ctl.load) begin
        idx     <= '0;
        phase_b <= (sui_pkg::sui_list_t'(list_select) == sui_pkg::LIST_B_MINUS_A);
      end else if (wrap) begin
        idx     <= '0;
        phase_b <= 1'b1;
      end else if (issue_a || issue_b) begin
        idx <= idx + CNT_W'(1);
      end
    end
    pipe_idx <= idx[IDX_W-1:0];
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q   <= sui_pkg::sui_cmd_t'(command);
      sel_q   <= sui_pkg::sui_list_t'(list_select);
      value_q <= element_value;
      pos_q   <= position;
    end
  end

  // Insert decision
  always_comb begin
    own_found = (cmd_q == sui_pkg::CMD_INS_A) ? found_a : found_b;
    own_size  = (cmd_q == sui_pkg::CMD_INS_A) ? size_a : size_b;
    own_full  = (own_size == CNT_W'(sui_pkg::SET_CAPACITY));
    ins_ok    = !own_found && !own_full;
    new_size  = own_size + CNT_W'(ins_ok);
  end

  // Memory write enables at finish of an insert
  always_comb begin
    a_val_we   = ctl.finish && (cmd_q == sui_pkg::CMD_INS_A) && ins_ok;
    b_val_we   = ctl.finish && (cmd_q == sui_pkg::CMD_INS_B) && ins_ok;
    a_sh_we    = a_val_we || (b_val_we && found_a);
    b_sh_we    = b_val_we || (a_val_we && found_b);
    a_sh_waddr = a_val_we ? size_a[IDX_W-1:0] : found_a_idx;
    b_sh_waddr = b_val_we ? size_b[IDX_W-1:0] : found_b_idx;
    a_sh_wdata = a_val_we ? found_b : 1'b1;
    b_sh_wdata = b_val_we ? found_a : 1'b1;
  end

  // Set A storage
  always_ff @(posedge clk) begin
    if (a_val_we) a_val_mem[size_a[IDX_W-1:0]] <= value_q;
    a_val_rd <= a_val_mem[idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (a_sh_we) a_sh_mem[a_sh_waddr] <= a_sh_wdata;
    a_sh_rd <= a_sh_mem[idx[IDX_W-1:0]];
  end

  // Set B storage
  always_ff @(posedge clk) begin
    if (b_val_we) b_val_mem[size_b[IDX_W-1:0]] <= value_q;
    b_val_rd <= b_val_mem[idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (b_sh_we) b_sh_mem[b_sh_waddr] <= b_sh_wdata;
    b_sh_rd <= b_sh_mem[idx[IDX_W-1:0]];
  end

  // Select whether a streamed entry belongs to the requested list
  always_comb begin
    ent_sh  = pipe_b_v ? b_sh_rd : a_sh_rd;
    ent_val = pipe_b_v ? b_val_rd : a_val_rd;
    unique case (sel_q)
      sui_pkg::LIST_UNION:     keep = pipe_b_v ? !ent_sh : 1'b1;
      sui_pkg::LIST_INTER:     keep = ent_sh;
      sui_pkg::LIST_A_MINUS_B: keep = !ent_sh;
      sui_pkg::LIST_B_MINUS_A: keep = !ent_sh;
    endcase
  end

  // Search matches and positional count
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      found_a <= 1'b0;
      found_b <= 1'b0;
      hit     <= 1'b0;
      cnt     <= '0;
    end else if (ctl.scan) begin
      if (pipe_a_v && (a_val_rd == value_q)) begin
        found_a     <= 1'b1;
        found_a_idx <= pipe_idx;
      end
      if (pipe_b_v && (b_val_rd == value_q)) begin
        found_b     <= 1'b1;
        found_b_idx <= pipe_idx;
      end
    end else if (ctl.walk && (pipe_a_v || pipe_b_v) && keep) begin
      if (!hit && (cnt == {1'b0, pos_q})) begin
        hit     <= 1'b1;
        hit_val <= ent_val;
      end
      if (cnt != sui_pkg::LEN_MAX) cnt <= cnt + LEN_W'(1);
    end
  end

  // Update set sizes
  always_ff @(posedge clk) begin
    if (rst) begin
      size_a <= '0;
      size_b <= '0;
    end else if (ctl.finish) begin
      if (cmd_q == sui_pkg::CMD_CLEAR) begin
        size_a <= '0;
        size_b <= '0;
      end else if (a_val_we) begin
        size_a <= new_size;
      end else if (b_val_we) begin
        size_b <= new_size;
      end
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish;
    end
    if (ctl.finish) begin
      unique case (cmd_q)
        sui_pkg::CMD_CLEAR: begin
          status      <= sui_pkg::STAT_OK;
          read_value  <= '0;
          list_length <= '0;
        end
        sui_pkg::CMD_INS_A, sui_pkg::CMD_INS_B: begin
          status      <= own_found ? sui_pkg::STAT_DUP
                       : own_full  ? sui_pkg::STAT_FULL : sui_pkg::STAT_OK;
          read_value  <= '0;
          list_length <= sui_pkg::len_sat(new_size);
        end
        sui_pkg::CMD_READ: begin
          status      <= hit ? sui_pkg::STAT_OK : sui_pkg::STAT_RANGE;
          read_value  <= hit ? hit_val : '0;
          list_length <= cnt;
        end
      endcase
    end
  end

endmodule

### rtl/set_union_intersection_engine.sv
// ---------------------------------------------------------------------------
// set_union_intersection_engine: two bounded ordered sets with derived lists
// Clear, insert into A or B, and positional read of union, intersection,
// A minus B or B minus A, one command at a time.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on status, read_value and list_length for one cycle with done
// high, and busy is already low in that cycle, so the next item may be
// taken there. Entries live in memories read one entry per cycle, so time
// per item follows the set sizes: clear goes straight to its finish, an
// insert searches both sets side by side, a read of A minus B or the
// intersection walks A, of B minus A walks B, and of the union walks A
// then B. With 128 entries per set the longest item is a union read.
// Results cannot be held off.
// ---------------------------------------------------------------------------
module set_union_intersection_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        command,
  input  logic signed [sui_pkg::VAL_W-1:0]  element_value,
  input  logic [1:0]                        list_select,
  input  logic [sui_pkg::POS_W-1:0]         position,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [sui_pkg::VAL_W-1:0]  read_value,
  output logic [sui_pkg::LEN_W-1:0]         list_length
);

  sui_pkg::sui_ctl_t ctl;
  sui_pkg::sui_sts_t sts;

  // Sequencer
  sui_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .sts     (sts),
    .ctl     (ctl),
    .busy    (busy)
  );

  // Storage and walker
  sui_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .command       (command),
    .element_value (element_value),
    .list_select   (list_select),
    .position      (position),
    .done          (done),
    .status        (status),
    .read_value    (read_value),
    .list_length   (list_length)
  );

endmodule

### rtl/sui_checker.sv
// ---------------------------------------------------------------------------
// sui_checker: port-level checks of the set union/intersection engine
// Watches the command handshake and the result strobe over time.
// ---------------------------------------------------------------------------
module sui_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic [1:0]                        status,
  input logic signed [sui_pkg::VAL_W-1:0]  read_value
);

  // A result shows only while the block is free for the next item
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // An accepted item makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // No result in the cycle right after an item is taken
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result strobe right after acceptance");

  // Any non-ok result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status != sui_pkg::STAT_OK)) |-> (read_value == '0))
    else $error("non-zero value with error status");

endmodule

bind set_union_intersection_engine sui_checker u_sui_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .read_value (read_value)
);

### tb/sv/set_engine_checker.sv
// ---------------------------------------------------------------------------
// set_engine_checker: result checker for the set union/intersection engine
// Watches accepted commands and done strobes, keeps its own copy of both
// sets with their shared flags, predicts each result and compares it field
// by field with what the engine returns, in order.
// ---------------------------------------------------------------------------
module set_engine_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        command,
  input  logic signed [sui_pkg::VAL_W-1:0]  element_value,
  input  logic [1:0]                        list_select,
  input  logic [sui_pkg::POS_W-1:0]         position,
  input  logic                              done,
  input  logic [1:0]                        status,
  input  logic signed [sui_pkg::VAL_W-1:0]  read_value,
  input  logic [sui_pkg::LEN_W-1:0]         list_length,
  output int                                mismatches,
  output int                                pending
);
  import sui_pkg::*;

  typedef struct {
    sui_cmd_t                cmd;
    sui_status_t             status;
    logic signed [VAL_W-1:0] value;
    logic [LEN_W-1:0]        len;
  } set_outcome_t;

  // Shadow copy of both sets
  logic signed [VAL_W-1:0] a_vals [SET_CAPACITY];
  logic signed [VAL_W-1:0] b_vals [SET_CAPACITY];
  bit                      a_shared [SET_CAPACITY];
  bit                      b_shared [SET_CAPACITY];
  int                      a_count;
  int                      b_count;

  set_outcome_t cmd_outcomes [$];

  // Add v to A or B unless already there or full; mark shared entries
  function automatic sui_status_t insert_value(input bit into_a,
                                               input logic signed [VAL_W-1:0] v);
    int own_n;
    int oth_n;
    int own_hit;
    int oth_hit;
    own_n   = into_a ? a_count : b_count;
    oth_n   = into_a ? b_count : a_count;
    own_hit = -1;
    oth_hit = -1;
    for (int i = 0; i < own_n; i++) begin
      if (own_hit < 0 && (into_a ? a_vals[i] : b_vals[i]) == v) own_hit = i;
    end
    if (own_hit >= 0) return STAT_DUP;
    if (own_n >= SET_CAPACITY) return STAT_FULL;
    for (int i = 0; i < oth_n; i++) begin
      if (oth_hit < 0 && (into_a ? b_vals[i] : a_vals[i]) == v) oth_hit = i;
    end
    if (into_a) begin
      a_vals[a_count]   = v;
      a_shared[a_count] = (oth_hit >= 0);
      if (oth_hit >= 0) b_shared[oth_hit] = 1'b1;
      a_count++;
    end else begin
      b_vals[b_count]   = v;
      b_shared[b_count] = (oth_hit >= 0);
      if (oth_hit >= 0) a_shared[oth_hit] = 1'b1;
      b_count++;
    end
    return STAT_OK;
  endfunction

  // Advance the shadow sets by one command and return its result
  function automatic set_outcome_t apply_set_command(
      input logic [1:0] cmd, input logic signed [VAL_W-1:0] v,
      input logic [1:0] sel, input logic [POS_W-1:0] pos);
    set_outcome_t o;
    int           cnt;
    bit           hit;
    bit           take;
    o.cmd    = sui_cmd_t'(cmd);
    o.status = STAT_OK;
    o.value  = '0;
    o.len    = '0;
    cnt      = 0;
    hit      = 1'b0;
    case (sui_cmd_t'(cmd))
      CMD_CLEAR: begin
        a_count = 0;
        b_count = 0;
      end
      CMD_INS_A: begin
        o.status = insert_value(1'b1, v);
        o.len    = LEN_W'(a_count);
      end
      CMD_INS_B: begin
        o.status = insert_value(1'b0, v);
        o.len    = LEN_W'(b_count);
      end
      default: begin
        // Walk A, then B; union continues counting into B
        for (int i = 0; i < a_count; i++) begin
          case (sui_list_t'(sel))
            LIST_UNION:     take = 1'b1;
            LIST_INTER:     take = a_shared[i];
            LIST_A_MINUS_B: take = !a_shared[i];
            default:        take = 1'b0;
          endcase
          if (take) begin
            if (!hit && cnt == pos) begin
              hit     = 1'b1;
              o.value = a_vals[i];
            end
            cnt++;
          end
        end
        for (int i = 0; i < b_count; i++) begin
          take = (sui_list_t'(sel) == LIST_UNION || sui_list_t'(sel) == LIST_B_MINUS_A)
                 && !b_shared[i];
          if (take) begin
            if (!hit && cnt == pos) begin
              hit     = 1'b1;
              o.value = b_vals[i];
            end
            cnt++;
          end
        end
        if (!hit) begin
          o.status = STAT_RANGE;
          o.value  = '0;
        end
        o.len = (cnt > int'(LEN_MAX)) ? LEN_MAX : LEN_W'(cnt);
      end
    endcase
    return o;
  endfunction

  // Check results first, then queue the prediction for a new item
  always @(posedge clk) begin : watch
    set_outcome_t want;
    if (rst) begin
      a_count    = 0;
      b_count    = 0;
      mismatches = 0;
      cmd_outcomes.delete();
    end else begin
      if (done) begin
        if (cmd_outcomes.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: status %0d value %0d length %0d",
                     status, read_value, list_length);
          mismatches++;
        end else begin
          want = cmd_outcomes.pop_front();
          if (want.status !== status || want.value !== read_value ||
              want.len !== list_length) begin
            if (mismatches < 10)
              $display("command %0d: got %0d/%0d/%0d, expected %0d/%0d/%0d",
                       want.cmd, status, read_value, list_length,
                       want.status, want.value, want.len);
            mismatches++;
          end
        end
      end
      if (start && !busy)
        cmd_outcomes.push_back(apply_set_command(command, element_value,
                                                 list_select, position));
    end
    pending <= cmd_outcomes.size();
  end

endmodule

### tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: top level for the set union/intersection engine
// Drives directed and random command streams in bursts with random gaps,
// including a full fill of both sets, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module testbench;
  import sui_pkg::*;

  localparam int ITEM_TARGET = 450;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [1:0]              command = CMD_CLEAR;
  logic signed [VAL_W-1:0] element_value = '0;
  logic [1:0]              list_select = LIST_UNION;
  logic [POS_W-1:0]        position = '0;
  logic                    busy;
  logic                    done;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] read_value;
  logic [LEN_W-1:0]        list_length;
  int                      mismatches;
  int                      pending;

  int  items_sent = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  bit  driving = 1'b0;

  set_union_intersection_engine uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .element_value(element_value),
    .list_select(list_select), .position(position),
    .done(done), .status(status), .read_value(read_value),
    .list_length(list_length)
  );

  set_engine_checker outcome_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .element_value(element_value),
    .list_select(list_select), .position(position),
    .done(done), .status(status), .read_value(read_value),
    .list_length(list_length), .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hold start until the item is taken; end bursts with a random gap
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] v,
                           input logic [1:0] sel, input logic [POS_W-1:0] pos);
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    start         <= 1'b1;
    driving        = 1'b1;
    command       <= cmd;
    element_value <= v;
    list_select   <= sel;
    position      <= pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 300)
                                                : $urandom_range(1, 6);
      start     <= 1'b0;
      driving    = 1'b0;
    end
  endtask

  // Drop start and wait until every predicted result has come back
  task automatic drain_outcomes;
    if (driving) begin
      start  <= 1'b0;
      driving = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] edge_value(input int k);
    case (k % 4)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] a_fill [SET_CAPACITY];
    logic [31:0] pool [12];
    logic [31:0] r;
    int          ops;
    int          pick;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty read, extremes, duplicates, shared entries, all lists
    send_item(CMD_READ,  32'h0,         LIST_UNION,     8'd0);
    send_item(CMD_INS_A, 32'h8000_0000, LIST_UNION,     8'd0);
    send_item(CMD_INS_A, 32'h7FFF_FFFF, LIST_INTER,     8'hFF);
    send_item(CMD_INS_A, 32'h0000_0000, LIST_A_MINUS_B, 8'h00);
    send_item(CMD_INS_A, 32'hFFFF_FFFF, LIST_B_MINUS_A, 8'hFF);
    send_item(CMD_INS_A, 32'h7FFF_FFFF, LIST_UNION,     8'd0);
    send_item(CMD_INS_B, 32'hFFFF_FFFF, LIST_UNION,     8'd0);
    send_item(CMD_INS_B, 32'h5555_5555, LIST_UNION,     8'd0);
    send_item(CMD_INS_B, 32'hAAAA_AAAA, LIST_UNION,     8'd0);
    send_item(CMD_INS_B, 32'h8000_0000, LIST_UNION,     8'd0);
    send_item(CMD_INS_B, 32'hFFFF_FFFF, LIST_UNION,     8'd0);
    send_item(CMD_READ,  32'hFFFF_FFFF, LIST_UNION,     8'd0);
    send_item(CMD_READ,  32'h0,         LIST_INTER,     8'd0);
    send_item(CMD_READ,  32'h0,         LIST_A_MINUS_B, 8'd0);
    send_item(CMD_READ,  32'h0,         LIST_B_MINUS_A, 8'd0);
    send_item(CMD_READ,  32'h0,         LIST_UNION,     8'd5);
    send_item(CMD_READ,  32'h0,         LIST_UNION,     8'd6);
    send_item(CMD_READ,  32'h0,         LIST_INTER,     8'd1);
    send_item(CMD_READ,  32'h0,         LIST_A_MINUS_B, 8'd255);
    send_item(CMD_READ,  32'h0,         LIST_B_MINUS_A, 8'd1);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF, LIST_B_MINUS_A, 8'hFF);
    send_item(CMD_READ,  32'h0,         LIST_INTER,     8'd0);
    send_item(CMD_INS_B, 32'h0000_0001, LIST_UNION,     8'd0);
    send_item(CMD_READ,  32'h0,         LIST_B_MINUS_A, 8'd0);
    drain_outcomes();

    // Fill A to capacity with distinct values, sampling lists on the way
    send_item(CMD_CLEAR, $urandom(), 2'($urandom()), 8'($urandom()));
    for (int i = 0; i < SET_CAPACITY; i++) begin
      r         = $urandom();
      a_fill[i] = {r[31:7], 7'(i)};
      send_item(CMD_INS_A, a_fill[i], 2'($urandom()), 8'($urandom()));
      if (i % 8 == 7)
        send_item(CMD_READ, $urandom(), 2'($urandom()), 8'($urandom_range(0, 255)));
    end
    // Fill B: every fourth entry shared with A, the rest B only
    for (int i = 0; i < SET_CAPACITY; i++) begin
      r = $urandom();
      send_item(CMD_INS_B, (i % 4 == 0) ? a_fill[i] : {r[31:8], 1'b1, 7'(i)},
                2'($urandom()), 8'($urandom()));
      if (i % 8 == 7)
        send_item(CMD_READ, $urandom(), 2'($urandom()), 8'($urandom_range(0, 255)));
    end
    // Duplicate and fresh inserts into full sets, then long-list reads
    send_item(CMD_INS_A, a_fill[5],   LIST_UNION, 8'd0);
    send_item(CMD_INS_A, $urandom(),  LIST_UNION, 8'd0);
    send_item(CMD_INS_B, a_fill[8],   LIST_UNION, 8'd0);
    send_item(CMD_INS_B, $urandom(),  LIST_UNION, 8'd0);
    send_item(CMD_READ,  32'h0, LIST_UNION,     8'd255);
    send_item(CMD_READ,  32'h0, LIST_UNION,     8'd223);
    send_item(CMD_READ,  32'h0, LIST_UNION,     8'd224);
    send_item(CMD_READ,  32'h0, LIST_INTER,     8'd31);
    send_item(CMD_READ,  32'h0, LIST_A_MINUS_B, 8'd95);
    send_item(CMD_READ,  32'h0, LIST_B_MINUS_A, 8'd96);
    drain_outcomes();

    // Random episodes over a small value pool so duplicates and overlap occur
    while (items_sent < ITEM_TARGET) begin
      for (int k = 0; k < 12; k++)
        pool[k] = ($urandom_range(0, 5) == 0) ? edge_value($urandom()) : $urandom();
      if ($urandom_range(0, 3) != 0)
        send_item(CMD_CLEAR, $urandom(), 2'($urandom()), 8'($urandom()));
      ops = $urandom_range(5, 25);
      for (int n = 0; n < ops; n++) begin
        pick = $urandom_range(0, 99);
        r    = ($urandom_range(0, 4) == 0) ? $urandom() : pool[$urandom_range(0, 11)];
        if (pick < 2)
          send_item(CMD_CLEAR, r, 2'($urandom()), 8'($urandom()));
        else if (pick < 40)
          send_item(CMD_INS_A, r, 2'($urandom()), 8'($urandom()));
        else if (pick < 78)
          send_item(CMD_INS_B, r, 2'($urandom()), 8'($urandom()));
        else
          send_item(CMD_READ, $urandom(), 2'($urandom()),
                    ($urandom_range(0, 6) == 0) ? 8'($urandom())
                                                : 8'($urandom_range(0, 20)));
      end
    end

    // Let trailing results and any stray strobes show up, then judge
    drain_outcomes();
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("set_union_intersection_engine: match");
    end else begin
      $display("set_union_intersection_engine: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("set_union_intersection_engine: mismatch");
    $finish;
  end

endmodule
